>>> hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the window front end and the root chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

   localparam int unsigned PIX_W   = 8;
   localparam int unsigned GRAD_W  = 21;   // Gx^2 + Gy^2 < 2 * 1024^2
   localparam int unsigned SUM_W   = 17;   // radicand, saturated: roots of 256 up clamp
   localparam int unsigned ROOT_W  = 9;    // floor root of SUM_W bits
   localparam int unsigned STAGES  = 9;    // one root bit per cell
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // what travels from one root cell to the next
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [SUM_W-1:0]  radicand;
      logic [ROOT_W-1:0] root;
   } root_bus_type;

endpackage : sem_pkg

`default_nettype wire

>>> hw/rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one read per cycle, registered read data held unless
// enabled; a read of the address being written returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 255
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : mem_ff[rd_addr];
      end
   end

endmodule : sem_ram

`default_nettype wire

>>> hw/rtl/sem_root_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Decides one bit of the floor root and hands the partial root on.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_root_cell
   import sem_pkg::*;
#(
   parameter int unsigned BIT = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire root_bus_type prev,
   output      root_bus_type next
);

   root_bus_type       next_ff, next_in;
   logic [ROOT_W-1:0]  trial;
   logic [2*ROOT_W-1:0] square;

   always_comb begin
      trial = prev.root | (ROOT_W'(1) << BIT);
      square = trial * trial;    // 9 x 9 bits
      next_in = prev;
      if ({1'b0, square} <= {{(2*ROOT_W-SUM_W+1){1'b0}}, prev.radicand}) begin
         next_in.root = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (advance) begin
         next_ff.valid <= next_in.valid;
      end
      if (advance) begin
         next_ff.last     <= next_in.last;
         next_ff.radicand <= next_in.radicand;
         next_ff.root     <= next_in.root;
      end
   end

   assign next = next_ff;

endmodule : sem_root_cell

`default_nettype wire

>>> hw/rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, 3x3
// Streams raster pixels through two line stores and a 3x3 window, forms
// Gx and Gy, and takes a clamped floor square root in a chain of cells.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pixel passes the RAM read, the window, the gradient
//   square and nine root cells on its way to the result.
// Throughput: one item per cycle; the whole pipe moves when the output is
//   free, so a stalled result holds every stage.
// Reset: synchronous; clears position, window and valid bits, width and
//   height return to 20. Line stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude
   import sem_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 255
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic [PIX_W-1:0] req_pixel_value,
   input  wire logic             req_frame_start,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [PIX_W-1:0] rsp_edge_value,
   output      logic             rsp_frame_last,
   input  wire logic             csr_write,
   input  wire logic             csr_index,
   input  wire logic [PIX_W-1:0] csr_data
);

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned CW = (AW > PIX_W) ? AW : PIX_W;

   // whole pipe advances unless a held result is blocked
   logic advance, accept;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept = req_valid && advance;

   // configuration
   logic [PIX_W-1:0] width_ff, height_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd20;
         height_ff <= 8'd20;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   logic [CW-1:0] eff_width;
   assign eff_width = (CW'(width_ff) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_ff);

   // position
   logic [PIX_W-1:0] col_ff, row_ff, col_in, row_in, col_cur, row_cur;
   logic [PIX_W:0]   col_inc;
   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      col_inc = {1'b0, col_cur} + 1'b1;
      col_in  = col_inc[PIX_W-1:0];
      row_in  = row_cur;
      if (CW'(col_inc[PIX_W-1:0]) >= eff_width || col_inc[PIX_W]) begin
         col_in = '0;
         row_in = (({1'b0, row_cur} + 1'b1) >= {1'b0, height_ff}) ? '0 : row_cur + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1: line store access
   // both stores are read as the pixel is taken and written back from the stage 1
   // registers at the same column when the pipe advances; the upper store takes the old middle value
   logic             in_range;
   logic [AW-1:0]    addr;
   logic [PIX_W-1:0] top_rd, mid_rd;
   logic             s1_valid_ff, s1_out_ff, s1_last_ff, s1_range_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic             line_wr;
   assign in_range = CW'(col_cur) < CW'(MAX_WIDTH);
   assign addr = in_range ? AW'(col_cur) : '0;
   assign line_wr = advance && s1_valid_ff && s1_range_ff;

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .wr_en(line_wr), .wr_addr(s1_addr_ff), .wr_data(mid_rd),
      .rd_en(advance), .rd_addr(addr), .rd_data(top_rd));
   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .wr_en(line_wr), .wr_addr(s1_addr_ff), .wr_data(s1_pix_ff),
      .rd_en(advance), .rd_addr(addr), .rd_data(mid_rd));

   logic             out_cond, last_cond;
   assign out_cond = row_cur >= 8'd2 && col_cur >= 8'd2 && row_cur < height_ff &&
                     CW'(col_cur) < eff_width;
   assign last_cond = ({1'b0, row_cur} + 1'b1 == {1'b0, height_ff}) &&
                      (CW'(col_cur) + 1'b1 == eff_width);
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (advance) begin
         s1_out_ff   <= out_cond;
         s1_last_ff  <= last_cond;
         s1_pix_ff   <= req_pixel_value;
         s1_range_ff <= in_range;
         s1_addr_ff  <= addr;
      end
   end

   // stage 2: window shift
   logic [PIX_W-1:0] win_ff [9];
   logic             s2_valid_ff, s2_last_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_out_ff;
         if (s1_valid_ff) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k*3]   <= win_ff[k*3+1];
               win_ff[k*3+1] <= win_ff[k*3+2];
            end
            win_ff[2] <= s1_range_ff ? top_rd : '0;
            win_ff[5] <= s1_range_ff ? mid_rd : '0;
            win_ff[8] <= s1_pix_ff;
         end
      end
      if (advance) s2_last_ff <= s1_last_ff;
   end

   // stage 3: gradients and their squares
   logic signed [11:0] gx, gy;
   always_comb begin
      gx = (12'(win_ff[2]) + {3'b0, win_ff[5], 1'b0} + 12'(win_ff[8]))
         - (12'(win_ff[0]) + {3'b0, win_ff[3], 1'b0} + 12'(win_ff[6]));
      gy = (12'(win_ff[6]) + {3'b0, win_ff[7], 1'b0} + 12'(win_ff[8]))
         - (12'(win_ff[0]) + {3'b0, win_ff[1], 1'b0} + 12'(win_ff[2]));
   end
   logic signed [23:0] gx2, gy2;
   assign gx2 = gx * gx;
   assign gy2 = gy * gy;

   // full sum, saturated into the radicand; anything past it clamps anyway
   logic [GRAD_W-1:0] grad_sum;
   assign grad_sum = GRAD_W'(gx2) + GRAD_W'(gy2);

   root_bus_type chain [STAGES+1];
   root_bus_type head_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= s2_valid_ff;
      end
      if (advance) begin
         head_ff.last     <= s2_last_ff;
         head_ff.radicand <= (|grad_sum[GRAD_W-1:SUM_W]) ? '1 : grad_sum[SUM_W-1:0];
         head_ff.root     <= '0;
      end
   end
   assign chain[0] = head_ff;

   // chain of root cells, most significant bit first
   for (genvar g = 0; g < STAGES; g++) begin : g_cell
      sem_root_cell #(.BIT(STAGES-1-g)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .prev(chain[g]), .next(chain[g+1]));
   end

   assign rsp_valid      = chain[STAGES].valid;
   assign rsp_frame_last = chain[STAGES].last;
   assign rsp_edge_value = chain[STAGES].root[ROOT_W-1] ? PIX_MAX :
                           chain[STAGES].root[PIX_W-1:0];

   // a blocked result must hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_value))
      else $error("held result changed");
   // the input stalls only while a result is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("stall without blocked result");
   // after an accepted pixel the column either advances by one or wraps to zero
   assert property (@(posedge clock) disable iff (reset)
      accept && !req_frame_start |=> col_ff == '0 || col_ff == $past(col_ff) + 1'b1)
      else $error("column jump");

endmodule : sobel_edge_magnitude

`default_nettype wire
